/* rtl/core/rssa_pkg.sv */
`timescale 1ns / 1ps
package rssa_pkg;

  localparam int NUM_SLABS   = 64;
  localparam int NUM_CLASSES = 8;
  localparam int SLOTS_MAX   = 64;

  localparam logic [6:0]  EMPTY_LINK  = 7'd64;
  localparam logic [31:0] RNG_SEED    = 32'h1234_5678;
  localparam logic [11:0] PAYLOAD_RST = 12'd4064;
  localparam logic        CMD_FETCH   = 1'b0;
  localparam logic        CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [2:0]  size_class;
    logic [11:0] obj_bytes;
    logic [6:0]  slot_limit;
    logic [5:0]  freed_slab;
    logic [11:0] freed_offset;
  } in_t;

  typedef struct packed {
    logic        granted;
    logic [5:0]  granted_slab;
    logic [5:0]  granted_slot;
    logic [11:0] slot_offset;
    logic        last_item;
  } out_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [2:0] low_set8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) n = 3'(i);
    end
    return n;
  endfunction

endpackage

/* rtl/core/rssa_ram.sv */
`timescale 1ns / 1ps
module rssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/rssa_div.sv */
`timescale 1ns / 1ps
module rssa_div
  import rssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [11:0] dividend,
  input  logic [11:0] divisor,
  output logic        done,
  output logic [11:0] quotient
);

  // restoring division, one quotient bit per cycle
  logic [12:0] rem_r, rem_nxt;
  logic [11:0] quo_r, quo_nxt;
  logic [11:0] dsr_r;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [12:0] shifted, trial;

  assign shifted = {rem_r[11:0], quo_r[11]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = 4'd12;
    end else if (cnt_r != 4'd0) begin
      if (!trial[12]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[10:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[10:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) dsr_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/core/randomized_slab_slot_allocator.sv */
`timescale 1ns / 1ps
// Slab slot allocator with randomised slot choice.
// Input: an item is taken at a clock edge with start high and busy low; busy
// stays high until the command has finished. A fetch (command 0) returns one
// transfer per granted slot on out_data, each marked by a one-cycle out_valid,
// with last_item set on the final one; an empty fetch returns a single transfer
// with granted low. A release (command 1) returns nothing.
// Steps: each slot passes through S_GRANT, a chunk scan in S_SCAN and S_EMIT
// (the 64-bit map is searched in 8-bit chunks from a random start bit); taking a
// fresh slab runs the 12-step divider in S_FDIV, a listed slab is read in
// S_LOAD, and a fetch closes in S_FIN. A release keeps busy high while the
// same divider runs in S_RDIV; one that names a slab never handed out is
// dropped without going busy. Each result is held back until the next grant
// or the close of its fetch so that the final one can be marked. The receiver
// cannot stall: each transfer is shown for one cycle. cfg_we writes
// payload_bytes; the user must raise it only while idle, as the block itself
// does not enforce it. Reset empties all class lists, clears the fresh-slab
// count, reloads the random seed and payload_bytes.
module randomized_slab_slot_allocator
  import rssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HEAD  = 4'd1;
  localparam logic [3:0] S_FDIV  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_GRANT = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_RLOAD = 4'd9;
  localparam logic [3:0] S_RDIV  = 4'd10;

  logic [3:0]   state_r, state_nxt;
  logic [11:0]  payload_r;
  logic [31:0]  rng_r, rng_nxt;
  logic [6:0]   head_r [NUM_CLASSES];
  logic [6:0]   fresh_r, fresh_nxt;
  logic [6:0]   got_r, got_nxt;
  logic [6:0]   want_r;
  logic [2:0]   cls_r;
  logic [11:0]  osize_r, offs_r;
  logic [5:0]   rslab_r;
  logic [5:0]   slab_r, slab_nxt;
  logic [63:0]  map_r, map_nxt;
  logic [11:0]  size_r, size_nxt;
  logic [6:0]   link_r, link_nxt;
  logic [127:0] scan_r, scan_nxt;
  logic [3:0]   chunk_r, chunk_nxt;
  logic [5:0]   bit_r, bit_nxt;
  logic         pend_v_r, pend_v_nxt;
  out_t         pend_r, pend_nxt;
  logic         ov_r, ov_nxt;
  out_t         od_r, od_nxt;

  logic         head_we;
  logic [6:0]   head_wd;

  logic         map_we, size_we, link_we;
  logic [5:0]   map_wa, link_wa, raddr;
  logic [63:0]  map_wd, map_rd;
  logic [11:0]  size_rd;
  logic [6:0]   link_wd, link_rd;

  logic         div_go, div_done;
  logic [11:0]  div_a, div_b, div_q;

  logic [6:0]   want_in, count;
  logic [5:0]   rot;
  logic [17:0]  prod;

  assign raddr = (state_r == S_IDLE) ? in_data.freed_slab : head_r[cls_r][5:0];
  assign want_in = (in_data.slot_limit > 7'(SLOTS_MAX)) ? 7'(SLOTS_MAX) : in_data.slot_limit;
  assign count = (div_q >= 12'(SLOTS_MAX)) ? 7'(SLOTS_MAX) : div_q[6:0];
  assign rot = rng_nxt[5:0];
  assign prod = {12'd0, bit_r} * {6'd0, size_r};

  always_comb begin
    state_nxt  = state_r;
    rng_nxt    = rng_r;
    fresh_nxt  = fresh_r;
    got_nxt    = got_r;
    slab_nxt   = slab_r;
    map_nxt    = map_r;
    size_nxt   = size_r;
    link_nxt   = link_r;
    scan_nxt   = scan_r;
    chunk_nxt  = chunk_r;
    bit_nxt    = bit_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    ov_nxt     = 1'b0;
    od_nxt     = od_r;
    head_we    = 1'b0;
    head_wd    = EMPTY_LINK;
    map_we     = 1'b0;
    map_wa     = slab_r;
    map_wd     = map_r;
    size_we    = 1'b0;
    link_we    = 1'b0;
    link_wa    = slab_r;
    link_wd    = EMPTY_LINK;
    div_go     = 1'b0;
    div_a      = payload_r;
    div_b      = osize_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          got_nxt    = '0;
          pend_v_nxt = 1'b0;
          if (in_data.command == CMD_FETCH) begin
            state_nxt = (want_in == 7'd0) ? S_FIN : S_HEAD;
          end else if ({1'b0, in_data.freed_slab} < fresh_r) begin
            state_nxt = S_RLOAD;
          end
        end
      end
      S_HEAD: begin
        if (!head_r[cls_r][6]) begin
          slab_nxt  = head_r[cls_r][5:0];
          state_nxt = S_LOAD;
        end else if (fresh_r >= 7'(NUM_SLABS) || osize_r == 12'd0) begin
          state_nxt = S_FIN;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          if (count == 7'd0) begin
            state_nxt = S_FIN;
          end else begin
            // fresh slab: slots below count free
            slab_nxt  = fresh_r[5:0];
            fresh_nxt = fresh_r + 7'd1;
            map_nxt   = ~(~64'd0 << count);
            size_nxt  = osize_r;
            link_nxt  = EMPTY_LINK;
            map_we    = 1'b1;
            map_wa    = fresh_r[5:0];
            map_wd    = ~(~64'd0 << count);
            size_we   = 1'b1;
            link_we   = 1'b1;
            link_wa   = fresh_r[5:0];
            head_we   = 1'b1;
            head_wd   = {1'b0, fresh_r[5:0]};
            state_nxt = S_GRANT;
          end
        end
      end
      S_LOAD: begin
        map_nxt   = map_rd;
        size_nxt  = size_rd;
        link_nxt  = link_rd;
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        if (got_r == want_r || map_r == 64'd0) begin
          state_nxt = S_END;
        end else begin
          rng_nxt   = xorshift32(rng_r);
          // bits at or above the rotation first, then wrap to the whole map
          scan_nxt  = {map_r, map_r & (~64'd0 << rot)};
          chunk_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_r[7:0] != 8'd0) begin
          bit_nxt   = {chunk_r[2:0], low_set8(scan_r[7:0])};
          state_nxt = S_EMIT;
        end else begin
          scan_nxt  = scan_r >> 8;
          chunk_nxt = chunk_r + 4'd1;
        end
      end
      S_EMIT: begin
        if (pend_v_r) begin
          ov_nxt = 1'b1;
          od_nxt = pend_r;
        end
        pend_v_nxt            = 1'b1;
        pend_nxt.granted      = 1'b1;
        pend_nxt.granted_slab = slab_r;
        pend_nxt.granted_slot = bit_r;
        pend_nxt.slot_offset  = prod[11:0];
        pend_nxt.last_item    = 1'b0;
        map_nxt    = map_r & ~(64'd1 << bit_r);
        map_we     = 1'b1;
        map_wd     = map_r & ~(64'd1 << bit_r);
        got_nxt    = got_r + 7'd1;
        state_nxt  = S_GRANT;
      end
      S_END: begin
        if (map_r == 64'd0) begin
          head_we = 1'b1;
          head_wd = link_r;
          link_we = 1'b1;
        end
        state_nxt = (got_r == want_r) ? S_FIN : S_HEAD;
      end
      S_FIN: begin
        ov_nxt = 1'b1;
        if (pend_v_r) begin
          od_nxt           = pend_r;
          od_nxt.last_item = 1'b1;
        end else begin
          od_nxt           = '0;
          od_nxt.last_item = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      S_RLOAD: begin
        map_nxt  = map_rd;
        size_nxt = size_rd;
        slab_nxt = rslab_r;
        if (size_rd == 12'd0) begin
          state_nxt = S_IDLE;
        end else begin
          div_go    = 1'b1;
          div_a     = offs_r;
          div_b     = size_rd;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          state_nxt = S_IDLE;
          if (div_q < 12'(SLOTS_MAX)) begin
            map_we = 1'b1;
            map_wd = map_r | (64'd1 << div_q[5:0]);
            if (map_r == 64'd0) begin
              link_we = 1'b1;
              link_wd = head_r[cls_r];
              head_we = 1'b1;
              head_wd = {1'b0, slab_r};
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      payload_r <= PAYLOAD_RST;
      rng_r     <= RNG_SEED;
      fresh_r   <= '0;
      pend_v_r  <= 1'b0;
      ov_r      <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) head_r[i] <= EMPTY_LINK;
    end else begin
      state_r  <= state_nxt;
      rng_r    <= rng_nxt;
      fresh_r  <= fresh_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) payload_r <= cfg_data;
      if (head_we) head_r[cls_r] <= head_wd;
    end
    got_r   <= got_nxt;
    slab_r  <= slab_nxt;
    map_r   <= map_nxt;
    size_r  <= size_nxt;
    link_r  <= link_nxt;
    scan_r  <= scan_nxt;
    chunk_r <= chunk_nxt;
    bit_r   <= bit_nxt;
    pend_r  <= pend_nxt;
    od_r    <= od_nxt;
    if (state_r == S_IDLE && start) begin
      cls_r   <= in_data.size_class;
      osize_r <= in_data.obj_bytes;
      want_r  <= want_in;
      rslab_r <= in_data.freed_slab;
      offs_r  <= in_data.freed_offset;
    end
  end

  rssa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  rssa_ram #(.WIDTH(64), .DEPTH(NUM_SLABS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_wa),
    .wdata (map_wd),
    .raddr (raddr),
    .rdata (map_rd)
  );

  rssa_ram #(.WIDTH(12), .DEPTH(NUM_SLABS)) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (fresh_r[5:0]),
    .wdata (osize_r),
    .raddr (raddr),
    .rdata (size_rd)
  );

  rssa_ram #(.WIDTH(7), .DEPTH(NUM_SLABS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .raddr (raddr),
    .rdata (link_rd)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

/* sim/rssa_checker.sv */
`timescale 1ns / 1ps
module rssa_checker
  import rssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_data,
  input  logic        out_valid,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data,
  output int          fails,
  output int          pending
);

  logic [63:0] free_map  [NUM_SLABS];
  logic [11:0] slab_size [NUM_SLABS];
  logic [6:0]  slab_link [NUM_SLABS];
  logic [6:0]  class_head[NUM_CLASSES];
  int          slabs_used;
  logic [31:0] rng;
  logic [11:0] payload;
  out_t        grant_q[$];
  int          err_cnt = 0;

  task automatic grant_slots(input in_t it);
    int          want;
    int          got;
    int          cnt;
    int          rot;
    int          pos;
    int          prod;
    logic [5:0]  s;
    logic [63:0] m;
    logic [63:0] r;
    logic [31:0] x;
    logic        have_prev;
    out_t        prev;
    out_t        res;
    want      = (it.slot_limit > SLOTS_MAX) ? SLOTS_MAX : it.slot_limit;
    got       = 0;
    have_prev = 1'b0;
    prev      = '0;
    while (got < want) begin
      if (class_head[it.size_class] == EMPTY_LINK) begin
        if (slabs_used >= NUM_SLABS) break;
        cnt = (it.obj_bytes != 0) ? payload / it.obj_bytes : 0;
        if (cnt == 0) break;
        if (cnt > 64) cnt = 64;
        s = slabs_used[5:0];
        slabs_used++;
        slab_size[s] = it.obj_bytes;
        free_map[s]  = (cnt == 64) ? {64{1'b1}} : ((64'd1 << cnt) - 64'd1);
        slab_link[s] = EMPTY_LINK;
        class_head[it.size_class] = {1'b0, s};
      end
      s = class_head[it.size_class][5:0];
      while (got < want && free_map[s] != 0) begin
        x = rng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rng = x;
        rot = x[5:0];
        m = free_map[s];
        r = (rot == 0) ? m : ((m >> rot) | (m << (64 - rot)));
        pos = 0;
        while (pos < 63 && !r[pos]) pos++;
        pos = (pos + rot) % 64;
        free_map[s][pos] = 1'b0;
        prod = pos * slab_size[s];
        res.granted      = 1'b1;
        res.granted_slab = s;
        res.granted_slot = pos[5:0];
        res.slot_offset  = prod[11:0];
        res.last_item    = 1'b0;
        if (have_prev) grant_q.push_back(prev);
        prev      = res;
        have_prev = 1'b1;
        got++;
      end
      // a full slab drops off its class list
      if (free_map[s] == 0) begin
        class_head[it.size_class] = slab_link[s];
        slab_link[s] = EMPTY_LINK;
      end
    end
    if (have_prev) begin
      prev.last_item = 1'b1;
      grant_q.push_back(prev);
    end else begin
      res = '0;
      res.last_item = 1'b1;
      grant_q.push_back(res);
    end
  endtask

  task automatic free_slot(input in_t it);
    int sz;
    int slot;
    if (it.freed_slab >= slabs_used) return;
    sz = slab_size[it.freed_slab];
    if (sz == 0) return;
    slot = it.freed_offset / sz;
    if (slot >= 64) return;
    if (free_map[it.freed_slab] == 0) begin
      slab_link[it.freed_slab] = class_head[it.size_class];
      class_head[it.size_class] = {1'b0, it.freed_slab};
    end
    free_map[it.freed_slab][slot] = 1'b1;
  endtask

  always @(posedge clk) begin
    out_t want_res;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLABS; i++) begin
        free_map[i]  = '0;
        slab_size[i] = '0;
        slab_link[i] = EMPTY_LINK;
      end
      for (int i = 0; i < NUM_CLASSES; i++) class_head[i] = EMPTY_LINK;
      slabs_used = 0;
      rng        = RNG_SEED;
      payload    = PAYLOAD_RST;
      grant_q.delete();
    end else begin
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          err_cnt++;
        end else begin
          want_res = grant_q.pop_front();
          if (out_data.granted !== want_res.granted) begin
            $error("granted: expected %0d, got %0d", want_res.granted, out_data.granted);
            err_cnt++;
          end
          if (out_data.granted_slab !== want_res.granted_slab) begin
            $error("granted_slab: expected %0d, got %0d",
                   want_res.granted_slab, out_data.granted_slab);
            err_cnt++;
          end
          if (out_data.granted_slot !== want_res.granted_slot) begin
            $error("granted_slot: expected %0d, got %0d",
                   want_res.granted_slot, out_data.granted_slot);
            err_cnt++;
          end
          if (out_data.slot_offset !== want_res.slot_offset) begin
            $error("slot_offset: expected %0d, got %0d",
                   want_res.slot_offset, out_data.slot_offset);
            err_cnt++;
          end
          if (out_data.last_item !== want_res.last_item) begin
            $error("last_item: expected %0d, got %0d",
                   want_res.last_item, out_data.last_item);
            err_cnt++;
          end
        end
      end
      if (cfg_we) payload = cfg_data;
      if (start && !busy) begin
        if (in_data.command == CMD_FETCH) grant_slots(in_data);
        else free_slot(in_data);
      end
    end
    pending <= grant_q.size();
    fails   <= err_cnt;
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rssa_pkg::*;

  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic [2:0]  cls;
    logic [5:0]  slab;
    logic [11:0] offset;
  } held_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we;
  logic [11:0] cfg_data;
  int          fails;
  int          pending;

  held_t       held_q[$];
  logic [2:0]  fetch_cls;
  int          quiet_cycles;
  logic        no_idle;

  randomized_slab_slot_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  rssa_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // keep the slots handed out so that releases can give them back
  always @(posedge clk) begin
    held_t h;
    if (rst_n && out_valid && out_data.granted) begin
      h.cls    = fetch_cls;
      h.slab   = out_data.granted_slab;
      h.offset = out_data.slot_offset;
      held_q.push_back(h);
    end
    if (start && !busy) fetch_cls = in_data.size_class;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("** randomized_slab_slot_allocator: FAILED **");
      $finish;
    end
  end

  task automatic send(input in_t it);
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_payload(input logic [11:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic in_t rand_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return in_t'(raw[$bits(in_t)-1:0]);
  endfunction

  function automatic in_t fetch_cmd(input int cls, input int sz, input int cnt);
    in_t it;
    it              = rand_item();
    it.command      = CMD_FETCH;
    it.size_class   = cls[2:0];
    it.obj_bytes    = sz[11:0];
    it.slot_limit   = cnt[6:0];
    return it;
  endfunction

  function automatic in_t release_cmd(input int cls, input int slab, input int off);
    in_t it;
    it              = rand_item();
    it.command      = CMD_RELEASE;
    it.size_class   = cls[2:0];
    it.freed_slab   = slab[5:0];
    it.freed_offset = off[11:0];
    return it;
  endfunction

  task automatic next_random(output in_t it);
    int    k;
    int    sz;
    held_t h;
    it = rand_item();
    if ($urandom_range(0, 99) < 55) begin
      k = $urandom_range(0, 99);
      if (k < 65) sz = $urandom_range(1, 120);
      else if (k < 92) sz = $urandom_range(1, 4095);
      else sz = 0;
      k = $urandom_range(0, 99);
      it = fetch_cmd($urandom_range(0, 7), sz,
                     (k < 80) ? $urandom_range(1, 8) : $urandom_range(0, 127));
    end else if (held_q.size() != 0 && $urandom_range(0, 99) < 80) begin
      k = $urandom_range(0, held_q.size() - 1);
      h = held_q[k];
      // now and then the slot is released twice
      if ($urandom_range(0, 9) != 0) held_q.delete(k);
      it = release_cmd(h.cls, h.slab, h.offset);
    end else begin
      it.command = CMD_RELEASE;
    end
  endtask

  initial begin
    in_t it;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the widest payload
    write_payload(12'd4095);
    send(release_cmd(0, 63, 0));        // slab never handed out
    send(fetch_cmd(0, 1, 64));          // full 64 slot slab
    send(fetch_cmd(1, 4095, 1));        // single slot slab, full at once
    send(fetch_cmd(2, 0, 5));           // zero object size
    send(fetch_cmd(3, 4095, 0));        // zero count
    send(fetch_cmd(4, 100, 127));       // count above 64, slab runs dry
    send(fetch_cmd(5, 4095, 64));
    send(release_cmd(1, 1, 0));         // full slab back onto its list
    send(release_cmd(0, 0, 4095));      // slot beyond 63
    send(release_cmd(0, 0, 7));
    send(release_cmd(0, 0, 7));         // already free
    send(fetch_cmd(1, 4095, 3));
    send(fetch_cmd(0, 1, 2));
    send(release_cmd(4, 2, 3999));
    send(fetch_cmd(6, 2048, 4));
    send(fetch_cmd(7, 1365, 64));
    drain();
    write_payload(12'd64);
    send(fetch_cmd(2, 65, 1));          // object larger than payload
    send(fetch_cmd(2, 64, 2));
    send(fetch_cmd(3, 1, 64));

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: write_payload(12'd64);
        1: write_payload(12'($urandom_range(65, 4094)));
        default: write_payload(12'd4095);
      endcase
      for (int n = 0; n < 80; n++) begin
        no_idle = (ph == 1 && n < 50);
        next_random(it);
        send(it);
        if (ph == 2 && n == 40) drain();
        idle_gap();
      end
    end

    // the last slabs are taken until the pool is spent
    no_idle = 1'b0;
    for (int n = 0; n < 6; n++) begin
      send(fetch_cmd(n, 2048, 64));
      idle_gap();
    end
    drain();
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("** randomized_slab_slot_allocator: PASSED **");
    end else begin
      $display("** randomized_slab_slot_allocator: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rssa_pkg.sv
rtl/core/rssa_ram.sv
rtl/core/rssa_div.sv
rtl/core/randomized_slab_slot_allocator.sv
sim/rssa_checker.sv
sim/tb.sv
